### rtl/core/csvt_pkg.sv
// Shared types and constants of the CSV byte tokenizer.
// Beat structs for both channels, token kinds, error codes, parser states.
// No dependencies.
package csvt_pkg;

	localparam logic [7:0]  CH_CR    = 8'h0D;
	localparam logic [7:0]  CH_LF    = 8'h0A;
	localparam logic [7:0]  CH_COMMA = 8'h2C;
	localparam logic [7:0]  CH_QUOTE = 8'h22;
	localparam logic [7:0]  CH_SPACE = 8'h20;
	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
	localparam logic [23:0] LINE_ONE = 24'd1;

	typedef enum logic [2:0] {
		KIND_BYTE = 3'd0,
		KIND_FEND = 3'd1,
		KIND_REND = 3'd2,
		KIND_EOS  = 3'd3,
		KIND_ERR  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_BEFORE_QUOTE = 2'd0,
		ERR_AFTER_QUOTE  = 2'd1,
		ERR_OPEN_QUOTE   = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		ST_FSTART = 4'd0,
		ST_UNQ    = 4'd1,
		ST_QUO    = 4'd2,
		ST_QSEEN  = 4'd3,
		ST_AFTQ   = 4'd4,
		ST_ROWCR  = 4'd5,
		ST_QCR    = 4'd6,
		ST_AQCR   = 4'd7,
		ST_ERR    = 4'd8
	} pstate_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_input;
	} text_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  field_byte;
		err_t        error_code;
		logic [23:0] line_number;
		logic        last_of_run;
	} token_item_t;

	// outcome of one byte in a simple parse context: at most one token
	typedef struct packed {
		logic       emit;
		kind_t      kind;
		logic [7:0] fbyte;
		err_t       code;
		pstate_t    nxt;
		logic       line_up;
		logic       rec_end;
	} sub_t;

	// load request from the parser side into the token queue
	typedef struct packed {
		logic       load;
		logic [1:0] cnt;
	} q_ctl_t;

endpackage

### rtl/core/csv_byte_tokenizer.sv
// Top level of the CSV byte tokenizer: input register, parser, token queue.
// Depends on csvt_pkg, csvt_parser and csvt_out_queue.
//
// Usage:
//   text channel  (text_valid/text_ready/text): one beat per CSV byte, or an
//   end-of-input beat that closes the stream and resets the parser.
//   token channel (token_valid/token_ready/token): field bytes, field end,
//   record end, end of stream and error tokens; last_of_run marks the final
//   token caused by one text beat.
//   A text beat is held in the input register, decoded combinationally by the
//   parser, and its tokens are registered in the token queue for output.
//   Throughput: one text beat per cycle while each beat yields at most one
//   token and the receiver is ready; a beat yielding more (up to 3) holds the
//   parser until its last token leaves the queue, which drains one per cycle.
//   Beats that yield no token (skipped spaces, held CR, opening quotes)
//   still take a step in the parser.
//   Reset: parser at field start, line count one, queue and input register
//   empty. No clearing pass.
//   Receiver stall: the queue holds its tokens, the parser waits, and the
//   input register keeps one beat, after which text_ready drops.
module csv_byte_tokenizer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_ready,
	input  csvt_pkg::text_item_t  text,
	output logic                  token_valid,
	input  logic                  token_ready,
	output csvt_pkg::token_item_t token
);

	logic                        valid_s1;
	csvt_pkg::text_item_t        item_s1;
	logic                        space;
	logic                        step;
	csvt_pkg::token_item_t [2:0] res;
	logic [1:0]                  cnt;
	csvt_pkg::q_ctl_t            ctl;

	assign step       = valid_s1 && space;
	assign text_ready = !valid_s1 || space;
	assign ctl.load   = step;
	assign ctl.cnt    = cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			item_s1 <= text;
		end
	end

	csvt_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res),
		.cnt    (cnt)
	);

	csvt_out_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.res         (res),
		.space       (space),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token       (token)
	);

`ifndef NO_ASSERTIONS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(item_s1))
		else $error("held text beat lost or changed before parsing");
`endif

endmodule

### rtl/core/csvt_parser.sv
// Parser state machine: parse state, record-open flag and line counter,
// plus the per-beat token decode (up to three tokens). Uses csvt_pkg.
module csvt_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  csvt_pkg::text_item_t           item,
	output csvt_pkg::token_item_t [2:0]    res,
	output logic [1:0]                     cnt
);

	csvt_pkg::pstate_t state_q, state_d;
	logic              open_q, open_d;
	logic [23:0]       line_q, line_d;

	function automatic csvt_pkg::sub_t none_f(csvt_pkg::pstate_t nxt);
		csvt_pkg::sub_t s;
		s.emit    = 1'b0;
		s.kind    = csvt_pkg::KIND_BYTE;
		s.fbyte   = 8'd0;
		s.code    = csvt_pkg::ERR_BEFORE_QUOTE;
		s.nxt     = nxt;
		s.line_up = 1'b0;
		s.rec_end = 1'b0;
		return s;
	endfunction

	function automatic csvt_pkg::sub_t plain_f(logic fstart, logic [7:0] b);
		csvt_pkg::sub_t s;
		s = none_f(csvt_pkg::ST_FSTART);
		if (b == csvt_pkg::CH_SPACE && fstart) begin
			s.nxt = csvt_pkg::ST_FSTART;
		end else if (b == csvt_pkg::CH_COMMA) begin
			s.emit = 1'b1;
			s.kind = csvt_pkg::KIND_FEND;
		end else if (b == csvt_pkg::CH_QUOTE) begin
			if (fstart) begin
				s.nxt = csvt_pkg::ST_QUO;
			end else begin
				s.emit = 1'b1;
				s.kind = csvt_pkg::KIND_ERR;
				s.code = csvt_pkg::ERR_BEFORE_QUOTE;
				s.nxt  = csvt_pkg::ST_ERR;
			end
		end else if (b == csvt_pkg::CH_LF) begin
			s.emit    = 1'b1;
			s.kind    = csvt_pkg::KIND_REND;
			s.line_up = 1'b1;
			s.rec_end = 1'b1;
		end else if (b == csvt_pkg::CH_CR) begin
			s.nxt = csvt_pkg::ST_ROWCR;
		end else begin
			s.emit  = 1'b1;
			s.fbyte = b;
			s.nxt   = csvt_pkg::ST_UNQ;
		end
		return s;
	endfunction

	function automatic csvt_pkg::sub_t quoted_f(logic [7:0] b);
		csvt_pkg::sub_t s;
		s = none_f(csvt_pkg::ST_QUO);
		if (b == csvt_pkg::CH_QUOTE) begin
			s.nxt = csvt_pkg::ST_QSEEN;
		end else if (b == csvt_pkg::CH_CR) begin
			s.nxt = csvt_pkg::ST_QCR;
		end else begin
			s.emit    = 1'b1;
			s.fbyte   = b;
			s.line_up = (b == csvt_pkg::CH_LF);
		end
		return s;
	endfunction

	function automatic csvt_pkg::sub_t after_f(logic [7:0] b);
		csvt_pkg::sub_t s;
		s = none_f(csvt_pkg::ST_AFTQ);
		if (b == csvt_pkg::CH_SPACE) begin
			s.nxt = csvt_pkg::ST_AFTQ;
		end else if (b == csvt_pkg::CH_COMMA) begin
			s.emit = 1'b1;
			s.kind = csvt_pkg::KIND_FEND;
			s.nxt  = csvt_pkg::ST_FSTART;
		end else if (b == csvt_pkg::CH_LF) begin
			s.emit    = 1'b1;
			s.kind    = csvt_pkg::KIND_REND;
			s.line_up = 1'b1;
			s.rec_end = 1'b1;
			s.nxt     = csvt_pkg::ST_FSTART;
		end else if (b == csvt_pkg::CH_CR) begin
			s.nxt = csvt_pkg::ST_AQCR;
		end else begin
			s.emit = 1'b1;
			s.kind = csvt_pkg::KIND_ERR;
			s.code = csvt_pkg::ERR_AFTER_QUOTE;
			s.nxt  = csvt_pkg::ST_ERR;
		end
		return s;
	endfunction

	function automatic csvt_pkg::token_item_t mk_f(csvt_pkg::kind_t k, logic [7:0] b,
			csvt_pkg::err_t c, logic [23:0] ln);
		csvt_pkg::token_item_t t;
		t.kind        = k;
		t.field_byte  = b;
		t.error_code  = c;
		t.line_number = ln;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csvt_pkg::ST_FSTART;
			open_q  <= 1'b0;
			line_q  <= csvt_pkg::LINE_ONE;
		end else if (step) begin
			state_q <= state_d;
			open_q  <= open_d;
			line_q  <= line_d;
		end
	end

	always_comb begin
		csvt_pkg::sub_t s;
		logic [7:0]     b;
		logic [1:0]     n;
		s = none_f(state_q);
		b = item.text_byte;
		n = 2'd0;
		res = '0;
		for (int i = 0; i < 3; i++) begin
			res[i] = mk_f(csvt_pkg::KIND_BYTE, 8'd0, csvt_pkg::ERR_BEFORE_QUOTE, line_q);
		end
		state_d = state_q;
		open_d  = open_q;
		line_d  = line_q;

		if (item.end_of_input) begin
			case (state_q)
				csvt_pkg::ST_ERR: begin
				end
				csvt_pkg::ST_QUO: begin
					res[n] = mk_f(csvt_pkg::KIND_ERR, 8'd0, csvt_pkg::ERR_OPEN_QUOTE, line_q);
					n = n + 2'd1;
				end
				csvt_pkg::ST_QCR: begin
					res[n] = mk_f(csvt_pkg::KIND_BYTE, csvt_pkg::CH_CR,
						csvt_pkg::ERR_BEFORE_QUOTE, line_q);
					n = n + 2'd1;
					res[n] = mk_f(csvt_pkg::KIND_ERR, 8'd0, csvt_pkg::ERR_OPEN_QUOTE, line_q);
					n = n + 2'd1;
				end
				csvt_pkg::ST_AQCR: begin
					res[n] = mk_f(csvt_pkg::KIND_ERR, 8'd0, csvt_pkg::ERR_AFTER_QUOTE, line_q);
					n = n + 2'd1;
				end
				csvt_pkg::ST_ROWCR: begin
					res[n] = mk_f(csvt_pkg::KIND_BYTE, csvt_pkg::CH_CR,
						csvt_pkg::ERR_BEFORE_QUOTE, line_q);
					n = n + 2'd1;
					res[n] = mk_f(csvt_pkg::KIND_REND, 8'd0, csvt_pkg::ERR_BEFORE_QUOTE, line_q);
					n = n + 2'd1;
				end
				csvt_pkg::ST_QSEEN, csvt_pkg::ST_AFTQ: begin
					res[n] = mk_f(csvt_pkg::KIND_REND, 8'd0, csvt_pkg::ERR_BEFORE_QUOTE, line_q);
					n = n + 2'd1;
				end
				default: begin
					if (open_q) begin
						res[n] = mk_f(csvt_pkg::KIND_REND, 8'd0,
							csvt_pkg::ERR_BEFORE_QUOTE, line_q);
						n = n + 2'd1;
					end
				end
			endcase
			res[n] = mk_f(csvt_pkg::KIND_EOS, 8'd0, csvt_pkg::ERR_BEFORE_QUOTE, line_q);
			n = n + 2'd1;
			// a new stream starts from the reset state
			state_d = csvt_pkg::ST_FSTART;
			open_d  = 1'b0;
			line_d  = csvt_pkg::LINE_ONE;
		end else if (state_q != csvt_pkg::ST_ERR) begin
			case (state_q)
				csvt_pkg::ST_ROWCR: begin
					if (b == csvt_pkg::CH_LF) begin
						s = plain_f(1'b1, b);
					end else begin
						// flush the held CR as data, then parse this byte
						res[n] = mk_f(csvt_pkg::KIND_BYTE, csvt_pkg::CH_CR,
							csvt_pkg::ERR_BEFORE_QUOTE, line_q);
						n = n + 2'd1;
						s = plain_f(1'b0, b);
					end
				end
				csvt_pkg::ST_QCR: begin
					if (b == csvt_pkg::CH_LF) begin
						s = none_f(csvt_pkg::ST_QUO);
						s.emit    = 1'b1;
						s.fbyte   = csvt_pkg::CH_LF;
						s.line_up = 1'b1;
					end else begin
						res[n] = mk_f(csvt_pkg::KIND_BYTE, csvt_pkg::CH_CR,
							csvt_pkg::ERR_BEFORE_QUOTE, line_q);
						n = n + 2'd1;
						s = quoted_f(b);
					end
				end
				csvt_pkg::ST_AQCR: begin
					if (b == csvt_pkg::CH_LF) begin
						s = after_f(b);
					end else begin
						s = none_f(csvt_pkg::ST_ERR);
						s.emit = 1'b1;
						s.kind = csvt_pkg::KIND_ERR;
						s.code = csvt_pkg::ERR_AFTER_QUOTE;
					end
				end
				csvt_pkg::ST_QSEEN: begin
					if (b == csvt_pkg::CH_QUOTE) begin
						s = none_f(csvt_pkg::ST_QUO);
						s.emit  = 1'b1;
						s.fbyte = csvt_pkg::CH_QUOTE;
					end else begin
						s = after_f(b);
					end
				end
				csvt_pkg::ST_QUO:  s = quoted_f(b);
				csvt_pkg::ST_AFTQ: s = after_f(b);
				csvt_pkg::ST_UNQ:  s = plain_f(1'b0, b);
				default:           s = plain_f(1'b1, b);
			endcase
			if (s.emit) begin
				res[n] = mk_f(s.kind, s.fbyte, s.code, line_q);
				n = n + 2'd1;
			end
			state_d = s.nxt;
			open_d  = !s.rec_end;
			if (s.line_up && line_q != csvt_pkg::LINE_MAX) begin
				line_d = line_q + 24'd1;
			end
		end
		cnt = n;
	end

`ifndef NO_ASSERTIONS
	a_eoi_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.end_of_input |=> state_q == csvt_pkg::ST_FSTART && !open_q
			&& line_q == csvt_pkg::LINE_ONE)
		else $error("end of input did not return parser to reset state");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != 24'd0)
		else $error("line counter reached zero");
`endif

endmodule

### rtl/core/csvt_out_queue.sv
// Three-entry token queue: loads all tokens of one text beat at once and
// drains one token beat per cycle while the receiver is ready. Uses csvt_pkg.
module csvt_out_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  csvt_pkg::q_ctl_t               ctl,
	input  csvt_pkg::token_item_t [2:0]    res,
	output logic                           space,
	output logic                           token_valid,
	input  logic                           token_ready,
	output csvt_pkg::token_item_t          token
);

	csvt_pkg::token_item_t [2:0] res_q;
	logic [1:0]                  n_q;
	logic                        pop;

	assign pop         = token_valid && token_ready;
	assign token_valid = (n_q != 2'd0);
	// room for a new run once the last token of the current one leaves
	assign space       = (n_q == 2'd0) || (n_q == 2'd1 && token_ready);

	always_comb begin
		token             = res_q[0];
		token.last_of_run = (n_q == 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 2'd0;
		end else if (ctl.load) begin
			n_q <= ctl.cnt;
		end else if (pop) begin
			n_q <= n_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			res_q <= res;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

`ifndef NO_ASSERTIONS
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> n_q == 2'd0 || (n_q == 2'd1 && pop))
		else $error("token run loaded over pending tokens");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> n_q == $past(ctl.cnt))
		else $error("queue count does not match loaded run");
`endif

endmodule

### tb/tb_csv_byte_tokenizer.sv
// Self-checking testbench for the CSV byte tokenizer: predicts the token stream
// per text beat and compares every token beat field by field.
// Depends on csvt_pkg and csv_byte_tokenizer.
import csvt_pkg::*;

class token_scoreboard;
	token_item_t want_q[$];
	token_item_t beat_toks[$];
	pstate_t     pst;
	bit          rec_open;
	logic [23:0] line_no;
	int          errors;
	int          checked;
	int          beats;
	int          live_beats;
	int          kind_seen[5];

	function new();
		restart();
	endfunction

	function void restart();
		pst = ST_FSTART;
		rec_open = 1'b0;
		line_no = LINE_ONE;
	endfunction

	// code field stays zero on tokens that are not errors
	function void emit(kind_t k, logic [7:0] b, err_t c);
		token_item_t t;
		t.kind = k;
		t.field_byte = b;
		t.error_code = c;
		t.line_number = line_no;
		t.last_of_run = 1'b0;
		if (beat_toks.size() < 3)
			beat_toks = {beat_toks, t};
	endfunction

	function void bump_line();
		if (line_no != LINE_MAX)
			line_no++;
	endfunction

	function void close_record();
		emit(KIND_REND, 8'h00, ERR_BEFORE_QUOTE);
		bump_line();
		pst = ST_FSTART;
		rec_open = 1'b0;
	endfunction

	function void plain_char(logic [7:0] b);
		if (b == CH_SPACE && pst == ST_FSTART)
			return;
		if (b == CH_COMMA) begin
			emit(KIND_FEND, 8'h00, ERR_BEFORE_QUOTE);
			pst = ST_FSTART;
			return;
		end
		if (b == CH_QUOTE) begin
			if (pst == ST_FSTART) begin
				pst = ST_QUO;
			end else begin
				emit(KIND_ERR, 8'h00, ERR_BEFORE_QUOTE);
				pst = ST_ERR;
			end
			return;
		end
		if (b == CH_LF) begin
			close_record();
			return;
		end
		if (b == CH_CR) begin
			pst = ST_ROWCR;
			return;
		end
		emit(KIND_BYTE, b, ERR_BEFORE_QUOTE);
		pst = ST_UNQ;
	endfunction

	function void quoted_char(logic [7:0] b);
		if (b == CH_QUOTE) begin
			pst = ST_QSEEN;
			return;
		end
		if (b == CH_CR) begin
			pst = ST_QCR;
			return;
		end
		emit(KIND_BYTE, b, ERR_BEFORE_QUOTE);
		if (b == CH_LF)
			bump_line();
	endfunction

	function void after_quote(logic [7:0] b);
		if (b == CH_SPACE)
			return;
		if (b == CH_COMMA) begin
			emit(KIND_FEND, 8'h00, ERR_BEFORE_QUOTE);
			pst = ST_FSTART;
			return;
		end
		if (b == CH_LF) begin
			close_record();
			return;
		end
		if (b == CH_CR) begin
			pst = ST_AQCR;
			return;
		end
		emit(KIND_ERR, 8'h00, ERR_AFTER_QUOTE);
		pst = ST_ERR;
	endfunction

	function void take_byte(logic [7:0] b);
		if (pst == ST_ERR)
			return;
		rec_open = 1'b1;
		case (pst)
			ST_ROWCR: begin
				if (b == CH_LF) begin
					close_record();
				end else begin
					emit(KIND_BYTE, CH_CR, ERR_BEFORE_QUOTE);
					pst = ST_UNQ;
					plain_char(b);
				end
			end
			ST_QCR: begin
				emit(KIND_BYTE, (b == CH_LF) ? CH_LF : CH_CR, ERR_BEFORE_QUOTE);
				pst = ST_QUO;
				if (b == CH_LF)
					bump_line();
				else
					quoted_char(b);
			end
			ST_AQCR: begin
				if (b == CH_LF) begin
					close_record();
				end else begin
					emit(KIND_ERR, 8'h00, ERR_AFTER_QUOTE);
					pst = ST_ERR;
				end
			end
			ST_QSEEN: begin
				if (b == CH_QUOTE) begin
					emit(KIND_BYTE, CH_QUOTE, ERR_BEFORE_QUOTE);
					pst = ST_QUO;
				end else begin
					pst = ST_AFTQ;
					after_quote(b);
				end
			end
			ST_QUO:  quoted_char(b);
			ST_AFTQ: after_quote(b);
			ST_UNQ:  plain_char(b);
			default: begin
				pst = ST_FSTART;
				plain_char(b);
			end
		endcase
	endfunction

	function void take_end();
		case (pst)
			ST_ERR: ;
			ST_QUO: emit(KIND_ERR, 8'h00, ERR_OPEN_QUOTE);
			ST_QCR: begin
				emit(KIND_BYTE, CH_CR, ERR_BEFORE_QUOTE);
				emit(KIND_ERR, 8'h00, ERR_OPEN_QUOTE);
			end
			ST_AQCR: emit(KIND_ERR, 8'h00, ERR_AFTER_QUOTE);
			ST_ROWCR: begin
				emit(KIND_BYTE, CH_CR, ERR_BEFORE_QUOTE);
				emit(KIND_REND, 8'h00, ERR_BEFORE_QUOTE);
			end
			ST_QSEEN, ST_AFTQ: emit(KIND_REND, 8'h00, ERR_BEFORE_QUOTE);
			default: begin
				if (rec_open)
					emit(KIND_REND, 8'h00, ERR_BEFORE_QUOTE);
			end
		endcase
		emit(KIND_EOS, 8'h00, ERR_BEFORE_QUOTE);
	endfunction

	function void note_text(text_item_t it);
		beat_toks.delete();
		beats++;
		if (it.end_of_input || pst != ST_ERR)
			live_beats++;
		if (it.end_of_input) begin
			take_end();
			restart();
		end else begin
			take_byte(it.text_byte);
		end
		if (beat_toks.size() > 0)
			beat_toks[beat_toks.size() - 1].last_of_run = 1'b1;
		foreach (beat_toks[i])
			want_q = {want_q, beat_toks[i]};
	endfunction

	function void diff(string name, logic [23:0] want, logic [23:0] seen);
		if (seen !== want) begin
			errors++;
			$display("%0t: token %0d %s expected %h got %h", $time, checked, name, want, seen);
		end
	endfunction

	function void check_token(token_item_t got);
		token_item_t exp;
		if (want_q.size() == 0) begin
			errors++;
			$display("%0t: token expected none got kind %0d byte %h", $time, got.kind,
				got.field_byte);
			return;
		end
		exp = want_q.pop_front();
		checked++;
		kind_seen[exp.kind]++;
		diff("kind", 24'(exp.kind), 24'(got.kind));
		diff("field_byte", 24'(exp.field_byte), 24'(got.field_byte));
		diff("error_code", 24'(exp.error_code), 24'(got.error_code));
		diff("line_number", exp.line_number, got.line_number);
		diff("last_of_run", 24'(exp.last_of_run), 24'(got.last_of_run));
	endfunction
endclass

module tb_csv_byte_tokenizer;
	typedef enum {
		F_EMPTY, F_PLAIN, F_QUOTED,
		F_BAD_QUOTE, F_JUNK_AFTER, F_OPEN_QUOTE, F_QUOTE_CR, F_NOISE
	} shape_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        text_valid;
	logic        text_ready;
	text_item_t  text;
	logic        token_valid;
	logic        token_ready;
	token_item_t token;

	token_scoreboard board = new();
	text_item_t      stream_q[$];
	bit              src_steady;
	bit              sink_steady;
	bit              cut_short;
	int              stall_req;

	csv_byte_tokenizer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text        (text),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token       (token)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_COMMA || b == CH_QUOTE || b == CH_CR || b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] quoted_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_QUOTE);
		return b;
	endfunction

	function automatic logic [7:0] letter();
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	task automatic push_byte(logic [7:0] b);
		text_item_t it;
		it.text_byte = b;
		it.end_of_input = 1'b0;
		stream_q = {stream_q, it};
	endtask

	// the byte field of an end beat is don't-care, so fill it with noise
	task automatic push_end();
		text_item_t it;
		it.text_byte = 8'($urandom_range(0, 255));
		it.end_of_input = 1'b1;
		stream_q = {stream_q, it};
	endtask

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic quoted_body();
		int n;
		int r;
		push_byte(CH_QUOTE);
		n = $urandom_range(0, 5);
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				push_byte(quoted_byte());
			end else if (r == 7) begin
				push_byte(CH_QUOTE);
				push_byte(CH_QUOTE);
			end else begin
				push_byte(CH_CR);
				push_byte(CH_LF);
			end
		end
		push_byte(CH_QUOTE);
	endtask

	task automatic make_field(bit broken);
		shape_t shape;
		int     r;
		if (broken && $urandom_range(0, 4) == 0) begin
			shape = shape_t'(F_BAD_QUOTE + $urandom_range(0, 4));
		end else begin
			r = $urandom_range(0, 9);
			shape = (r == 0) ? F_EMPTY : (r < 6) ? F_PLAIN : F_QUOTED;
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) push_byte(CH_SPACE);
		case (shape)
			F_EMPTY: ;
			F_PLAIN: begin
				repeat ($urandom_range(1, 5)) push_byte(plain_byte());
				// bare CR inside a field stays data
				if ($urandom_range(0, 5) == 0) begin
					push_byte(CH_CR);
					push_byte(plain_byte());
				end
			end
			F_QUOTED: begin
				quoted_body();
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 2)) push_byte(CH_SPACE);
			end
			F_BAD_QUOTE: begin
				push_byte(letter());
				push_byte(CH_QUOTE);
				push_byte(letter());
			end
			F_JUNK_AFTER: begin
				quoted_body();
				push_byte(letter());
			end
			F_OPEN_QUOTE: begin
				push_byte(CH_QUOTE);
				repeat ($urandom_range(0, 3)) push_byte(quoted_byte());
				cut_short = 1'b1;
			end
			F_QUOTE_CR: begin
				quoted_body();
				push_byte(CH_CR);
				if ($urandom_range(0, 1) == 0)
					push_byte(letter());
				else
					cut_short = 1'b1;
			end
			default: repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic make_stream(bit broken);
		int n_rec;
		int n_fld;
		int ending;
		cut_short = 1'b0;
		n_rec = $urandom_range(1, 4);
		for (int r = 0; r < n_rec && !cut_short; r++) begin
			n_fld = $urandom_range(1, 4);
			for (int f = 0; f < n_fld && !cut_short; f++) begin
				if (f > 0)
					push_byte(CH_COMMA);
				make_field(broken);
			end
			if (!cut_short) begin
				// last record may end in LF, CR LF, a lone CR or nothing
				ending = $urandom_range(0, (r == n_rec - 1) ? 3 : 1);
				if (ending == 1 || ending == 2)
					push_byte(CH_CR);
				if (ending <= 1)
					push_byte(CH_LF);
			end
		end
		push_end();
	endtask

	// call at a falling edge; returns at a falling edge with valid low
	task automatic send_stream();
		int gap;
		foreach (stream_q[i]) begin
			text <= stream_q[i];
			text_valid <= 1'b1;
			@(posedge clk);
			while (!text_ready)
				@(posedge clk);
			board.note_text(stream_q[i]);
			@(negedge clk);
			gap = (!src_steady && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
			if (i == stream_q.size() - 1 && gap == 0)
				gap = 1;
			if (gap > 0) begin
				text_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		stream_q.delete();
	endtask

	task automatic drain();
		while (board.want_q.size() != 0)
			@(negedge clk);
	endtask

	// token side: check at the rising edge, pick ready at the falling edge
	initial begin
		int hold_left;
		int gap_left;
		hold_left = 0;
		gap_left = 0;
		token_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && token_valid && token_ready)
				board.check_token(token);
			@(negedge clk);
			if (stall_req > 0) begin
				hold_left = stall_req;
				stall_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				token_ready <= 1'b0;
			end else if (sink_steady) begin
				token_ready <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				token_ready <= 1'b0;
			end else begin
				token_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					gap_left = pick_gap();
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		text_valid = 1'b0;
		text = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// byte extremes, skipped space, doubled quote, spaces after close, CR LF
		push_byte(CH_SPACE);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_COMMA);
		push_str("\"a\"\"\" ,");
		push_byte(CH_CR);
		push_byte(CH_LF);
		// bare CR as data, then quote inside an unquoted field; rest ignored
		push_str("x");
		push_byte(CH_CR);
		push_str("y\"z");
		push_end();
		// quoted line break, then CR pending inside an open quote at end
		push_byte(CH_QUOTE);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_CR);
		push_end();
		// closing quote right before end of input
		push_str("\"q\"");
		push_end();
		send_stream();

		// fill the block while the token side holds off
		stall_req = 80;
		src_steady = 1'b1;
		while (stream_q.size() < 24)
			make_stream($urandom_range(0, 3) == 0);
		send_stream();
		src_steady = 1'b0;
		drain();

		src_steady = 1'b1;
		sink_steady = 1'b1;
		make_stream(1'b0);
		send_stream();
		src_steady = 1'b0;
		sink_steady = 1'b0;

		while (board.beats < 150) begin
			make_stream($urandom_range(0, 3) == 0);
			send_stream();
		end

		drain();
		repeat (20) @(negedge clk);
		$display("covered %0d text beats (%0d parsed), %0d streams, %0d tokens checked",
			board.beats, board.live_beats, board.kind_seen[KIND_EOS], board.checked);
		$display("tokens seen: %0d field bytes, %0d field ends, %0d record ends, %0d errors",
			board.kind_seen[KIND_BYTE], board.kind_seen[KIND_FEND],
			board.kind_seen[KIND_REND], board.kind_seen[KIND_ERR]);
		if (board.errors == 0 && board.want_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

### files.f
rtl/core/csvt_pkg.sv
rtl/core/csvt_parser.sv
rtl/core/csvt_out_queue.sv
rtl/core/csv_byte_tokenizer.sv
tb/tb_csv_byte_tokenizer.sv
